// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the hit aggregator.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dhagg_pkg.sv =====
// Package for the detector hit aggregator: sizes, codes, request types and
// the detector id to slot decoder. Depends on nothing.
package dhagg_pkg;

	localparam int GAMMA_CHANNELS   = 111;
	localparam int SILICON_PER_BANK = 24;
	localparam int HIT_STORE_DEPTH  = 512;

	localparam int SLOT_COUNT = 2 * GAMMA_CHANNELS + 2 * SILICON_PER_BANK;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int HIT_W      = $clog2(HIT_STORE_DEPTH);
	localparam int COUNT_W    = HIT_W + 1;

	localparam int ID_W      = 9;
	localparam int DEP_W     = 24;
	localparam int TIME_W    = 32;
	localparam int POS_W     = 20;
	localparam int ENERGY_W  = 32;
	localparam int STATUS_W  = 3;
	localparam int OUT_IDX_W = 9;

	// Detector id banks
	localparam int ID_GA_LO   = 1;
	localparam int ID_GA_HI   = 110;
	localparam int ID_GB_LO   = 401;
	localparam int ID_GB_HI   = 510;
	localparam int ID_GB_BASE = 400;
	localparam int ID_SA_LO   = 200;
	localparam int ID_SA_HI   = 223;
	localparam int ID_SB_LO   = 300;
	localparam int ID_SB_HI   = 323;

	// Commands
	localparam logic CMD_STEP = 1'b0;
	localparam logic CMD_EOE  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_NEW     = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_ADD     = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_ZERO    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_CLEAR   = 3'd4;

	typedef struct packed {
		logic              known;
		logic [SLOT_W-1:0] slot;
	} slot_sel_t;

	// Slot table update: clear all valid bits, or open one slot
	typedef struct packed {
		logic              clear;
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [HIT_W-1:0]  hit;
	} slot_wr_t;

	// Energy store request: read a record, seed a record, or write back the sum
	typedef struct packed {
		logic             rd;
		logic             init;
		logic             acc;
		logic [HIT_W-1:0] hit;
		logic [DEP_W-1:0] dep;
	} energy_req_t;

	function automatic slot_sel_t slot_of(input logic [ID_W-1:0] id);
		slot_sel_t r;
		r.known = 1'b1;
		r.slot  = '0;
		if (int'(id) >= ID_GA_LO && int'(id) <= ID_GA_HI) begin
			r.slot = SLOT_W'(id);
		end else if (int'(id) >= ID_GB_LO && int'(id) <= ID_GB_HI) begin
			r.slot = SLOT_W'(int'(id) - ID_GB_BASE + GAMMA_CHANNELS);
		end else if (int'(id) >= ID_SA_LO && int'(id) <= ID_SA_HI) begin
			r.slot = SLOT_W'(int'(id) - ID_SA_LO + 2 * GAMMA_CHANNELS);
		end else if (int'(id) >= ID_SB_LO && int'(id) <= ID_SB_HI) begin
			r.slot = SLOT_W'(int'(id) - ID_SB_LO + 2 * GAMMA_CHANNELS + SILICON_PER_BANK);
		end else begin
			r.known = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/dhagg_slot_tbl.sv =====
// Slot table: per-slot valid bits in flip-flops and the slot-to-hit index memory.
// Depends on dhagg_pkg.
module dhagg_slot_tbl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [dhagg_pkg::SLOT_W-1:0] rd_slot,
	input  dhagg_pkg::slot_wr_t       wr,
	output logic                      rd_valid,
	output logic [dhagg_pkg::HIT_W-1:0] rd_hit
);
	import dhagg_pkg::*;

	logic [SLOT_COUNT-1:0] valid_q;
	logic                  rd_valid_q;
	logic [HIT_W-1:0]      rd_hit_q;
	logic [HIT_W-1:0]      idx_mem [SLOT_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.clear) begin
				valid_q <= '0;
			end else if (wr.en) begin
				valid_q[wr.slot] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_slot];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			idx_mem[wr.slot] <= wr.hit;
		end
		if (rd_en) begin
			rd_hit_q <= idx_mem[rd_slot];
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_hit   = rd_hit_q;

endmodule

// ===== rtl/dhagg_energy_acc.sv =====
// Energy store: per-hit energy sum memory with a saturating accumulate.
// Depends on dhagg_pkg.
module dhagg_energy_acc (
	input  logic                          clk,
	input  dhagg_pkg::energy_req_t        req,
	output logic [dhagg_pkg::ENERGY_W-1:0] sum
);
	import dhagg_pkg::*;

	logic [ENERGY_W-1:0] energy_mem [HIT_STORE_DEPTH];
	logic [ENERGY_W-1:0] rd_data_q;
	logic [HIT_W-1:0]    hit_q;
	logic [ENERGY_W:0]   raw;

	// Saturate on carry out
	assign raw = {1'b0, rd_data_q} + (ENERGY_W + 1)'(req.dep);
	assign sum = raw[ENERGY_W] ? '1 : raw[ENERGY_W-1:0];

	always_ff @(posedge clk) begin
		if (req.init) begin
			energy_mem[req.hit] <= ENERGY_W'(req.dep);
		end else if (req.acc) begin
			energy_mem[hit_q] <= sum;
		end
		if (req.rd) begin
			rd_data_q <= energy_mem[req.hit];
			hit_q     <= req.hit;
		end
	end

endmodule

// ===== rtl/detector_hit_aggregator_top.sv =====
// Top level of the detector hit aggregator: command handshake, sequencer,
// hit counter and result registers. Depends on dhagg_pkg, dhagg_slot_tbl,
// dhagg_energy_acc and assert_macros.svh.
//
// Channel   Direction  Handshake            Payload
// request   in         start / busy         command, det_id, energy_deposit,
//                                           step_time, pos_x, pos_y, pos_z
// result    out        done (one-cycle)     status, hit_index, hit_detector,
//                                           energy_total, first_time,
//                                           first_x, first_y, first_z
//
// A request is taken when start is high and busy is low. One result follows
// each request, shown for exactly one cycle with done high.
// The slot table read is registered on accept. End of event, zero deposit,
// unknown id and new hit are decided in S_LOOK and registered as the result;
// a deposit that adds to an open hit reads the energy memory in S_LOOK and
// writes back the sum in S_ACC. busy drops as the result is registered, so
// the next request may be accepted in the cycle done is high.
// Reset clears the valid bits and hit count at once; no clearing pass is run.
// The receiver cannot stall: done is never held off.
module detector_hit_aggregator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 command,
	input  logic [dhagg_pkg::ID_W-1:0]           det_id,
	input  logic [dhagg_pkg::DEP_W-1:0]          energy_deposit,
	input  logic [dhagg_pkg::TIME_W-1:0]         step_time,
	input  logic signed [dhagg_pkg::POS_W-1:0]   pos_x,
	input  logic signed [dhagg_pkg::POS_W-1:0]   pos_y,
	input  logic signed [dhagg_pkg::POS_W-1:0]   pos_z,
	output logic                                 done,
	output logic [dhagg_pkg::STATUS_W-1:0]       status,
	output logic [dhagg_pkg::OUT_IDX_W-1:0]      hit_index,
	output logic [dhagg_pkg::ID_W-1:0]           hit_detector,
	output logic [dhagg_pkg::ENERGY_W-1:0]       energy_total,
	output logic [dhagg_pkg::TIME_W-1:0]         first_time,
	output logic signed [dhagg_pkg::POS_W-1:0]   first_x,
	output logic signed [dhagg_pkg::POS_W-1:0]   first_y,
	output logic signed [dhagg_pkg::POS_W-1:0]   first_z
);
	import dhagg_pkg::*;

	`include "assert_macros.svh"

	// Sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_ACC  = 2'd2;

	logic [1:0]             state_q;
	logic [1:0]             state_d;
	logic                   accept;

	// Request held for the whole item
	logic                   cmd_q;
	logic [ID_W-1:0]        id_q;
	logic [DEP_W-1:0]       dep_q;
	logic [TIME_W-1:0]      time_q;
	logic [POS_W-1:0]       x_q;
	logic [POS_W-1:0]       y_q;
	logic [POS_W-1:0]       z_q;
	slot_sel_t              sel_q;
	slot_sel_t              sel_in;

	logic [COUNT_W-1:0]     hit_count_q;
	logic [COUNT_W-1:0]     hit_count_d;
	logic [HIT_W-1:0]       hit_q;
	logic [HIT_W-1:0]       hit_d;

	logic                   slot_valid;
	logic [HIT_W-1:0]       slot_hit;
	slot_wr_t               slot_wr;
	energy_req_t            e_req;
	logic [ENERGY_W-1:0]    e_sum;

	// Next result
	logic                   res_en;
	logic [STATUS_W-1:0]    res_status;
	logic [OUT_IDX_W-1:0]   res_index;
	logic [ID_W-1:0]        res_det;
	logic [ENERGY_W-1:0]    res_energy;
	logic                   res_first;

	// Result registers
	logic                   done_q;
	logic [STATUS_W-1:0]    status_q;
	logic [OUT_IDX_W-1:0]   index_q;
	logic [ID_W-1:0]        det_q;
	logic [ENERGY_W-1:0]    energy_q;
	logic [TIME_W-1:0]      ftime_q;
	logic [POS_W-1:0]       fx_q;
	logic [POS_W-1:0]       fy_q;
	logic [POS_W-1:0]       fz_q;

	logic                   idx_in_step;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign sel_in = slot_of(det_id);

	// Slot lookup is issued straight from the request ports on accept
	dhagg_slot_tbl u_slot_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_slot  (sel_in.slot),
		.wr       (slot_wr),
		.rd_valid (slot_valid),
		.rd_hit   (slot_hit)
	);

	dhagg_energy_acc u_energy_acc (
		.clk (clk),
		.req (e_req),
		.sum (e_sum)
	);

	// Capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			id_q   <= det_id;
			dep_q  <= energy_deposit;
			time_q <= step_time;
			x_q    <= pos_x;
			y_q    <= pos_y;
			z_q    <= pos_z;
			sel_q  <= sel_in;
		end
		hit_q <= hit_d;
	end

	// Decide the outcome once the slot table answers; finish an add in S_ACC
	always_comb begin
		state_d     = state_q;
		hit_count_d = hit_count_q;
		hit_d       = hit_q;
		slot_wr     = '0;
		slot_wr.slot = sel_q.slot;
		slot_wr.hit  = hit_count_q[HIT_W-1:0];
		e_req       = '0;
		e_req.dep   = dep_q;
		e_req.hit   = hit_count_q[HIT_W-1:0];
		res_en      = 1'b0;
		res_status  = STAT_ZERO;
		res_index   = '0;
		res_det     = '0;
		res_energy  = '0;
		res_first   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				state_d = S_IDLE;
				res_en  = 1'b1;
				if (cmd_q == CMD_EOE) begin
					slot_wr.clear = 1'b1;
					hit_count_d   = '0;
					res_status    = STAT_CLEAR;
				end else if (dep_q == '0) begin
					res_status = STAT_ZERO;
				end else if (!sel_q.known) begin
					res_status = STAT_UNKNOWN;
					res_det    = id_q;
				end else if (!slot_valid) begin
					res_det = id_q;
					if (hit_count_q >= COUNT_W'(HIT_STORE_DEPTH)) begin
						res_status = STAT_UNKNOWN;
					end else begin
						// Open a hit: seed its energy and take the next index
						slot_wr.en  = 1'b1;
						e_req.init  = 1'b1;
						hit_count_d = hit_count_q + COUNT_W'(1);
						res_status  = STAT_NEW;
						res_index   = hit_count_q[OUT_IDX_W-1:0];
						res_energy  = ENERGY_W'(dep_q);
						res_first   = 1'b1;
					end
				end else begin
					// Open hit: fetch its running sum
					res_en    = 1'b0;
					e_req.rd  = 1'b1;
					e_req.hit = slot_hit;
					hit_d     = slot_hit;
					state_d   = S_ACC;
				end
			end
			S_ACC: begin
				state_d    = S_IDLE;
				e_req.acc  = 1'b1;
				res_en     = 1'b1;
				res_status = STAT_ADD;
				res_index  = hit_q[OUT_IDX_W-1:0];
				res_det    = id_q;
				res_energy = e_sum;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hit_count_q <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			hit_count_q <= hit_count_d;
			done_q      <= res_en;
		end
	end

	// Result payload; time and position pass out only on a new hit
	always_ff @(posedge clk) begin
		if (res_en) begin
			status_q <= res_status;
			index_q  <= res_index;
			det_q    <= res_det;
			energy_q <= res_energy;
			ftime_q  <= res_first ? time_q : '0;
			fx_q     <= res_first ? x_q : '0;
			fy_q     <= res_first ? y_q : '0;
			fz_q     <= res_first ? z_q : '0;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign hit_index    = index_q;
	assign hit_detector = det_q;
	assign energy_total = energy_q;
	assign first_time   = ftime_q;
	assign first_x      = fx_q;
	assign first_y      = fy_q;
	assign first_z      = fz_q;

	// Checks
	assign idx_in_step = (hit_count_q == COUNT_W'(hit_index) + COUNT_W'(1));

	`ASSERT_IMPLY(a_done_not_busy, clk, arst_n, done, !busy, "result shown while busy")
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy, "accepted request not held busy")
	`ASSERT_IMPLY(a_new_counts, clk, arst_n, done && status == STAT_NEW, idx_in_step, "index off count")
	`ASSERT_IMPLY(a_clear_count, clk, arst_n, done && status == STAT_CLEAR, ~|hit_count_q, "stale count")

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for detector_hit_aggregator_top: a directed table
// followed by random events, checked against an in-bench hit aggregation model.
// Depends on dhagg_pkg and the RTL of the hit aggregator.
`timescale 1ns / 100ps

module tb;
	import dhagg_pkg::*;

	// Cycles without any accepted request or result before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 2000;
	// Random requests to send after the directed table.
	localparam int RANDOM_STEPS   = 1000;
	// Cap on printed mismatch lines.
	localparam int MAX_REPORTS    = 40;

	// One request as it goes onto the command ports.
	typedef struct packed {
		logic                cmd;
		logic [ID_W-1:0]     id;
		logic [DEP_W-1:0]    dep;
		logic [TIME_W-1:0]   t;
		logic [POS_W-1:0]    x;
		logic [POS_W-1:0]    y;
		logic [POS_W-1:0]    z;
	} step_req_t;

	// One result as it shows up on the result ports.
	typedef struct packed {
		logic [STATUS_W-1:0]  st;
		logic [OUT_IDX_W-1:0] hit_idx;
		logic [ID_W-1:0]      det;
		logic [ENERGY_W-1:0]  energy;
		logic [TIME_W-1:0]    t_first;
		logic [POS_W-1:0]     x0;
		logic [POS_W-1:0]     y0;
		logic [POS_W-1:0]     z0;
	} hit_report_t;

	// DUT ports; every input starts at a known value.
	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic                    command = CMD_STEP;
	logic [ID_W-1:0]         det_id = '0;
	logic [DEP_W-1:0]        energy_deposit = '0;
	logic [TIME_W-1:0]       step_time = '0;
	logic signed [POS_W-1:0] pos_x = '0;
	logic signed [POS_W-1:0] pos_y = '0;
	logic signed [POS_W-1:0] pos_z = '0;
	logic                    done;
	logic [STATUS_W-1:0]     status;
	logic [OUT_IDX_W-1:0]    hit_index;
	logic [ID_W-1:0]         hit_detector;
	logic [ENERGY_W-1:0]     energy_total;
	logic [TIME_W-1:0]       first_time;
	logic signed [POS_W-1:0] first_x;
	logic signed [POS_W-1:0] first_y;
	logic signed [POS_W-1:0] first_z;

	// Model state: open channels, their hit records, the running energy sums.
	logic [SLOT_COUNT-1:0]  chan_open = '0;
	logic [HIT_W-1:0]       chan_hit [SLOT_COUNT];
	logic [ENERGY_W-1:0]    hit_energy [HIT_STORE_DEPTH];
	logic [COUNT_W-1:0]     hits_opened = '0;

	// Results owed by the block, oldest first.
	hit_report_t hit_reports_due[$];

	// Directed table, kept as three parallel columns.
	step_req_t   dir_req[$];
	bit          dir_typed[$];
	hit_report_t dir_want[$];

	int fail_count = 0;
	int live_steps = 0;   // requests sent so far
	int idle_pct   = 0;   // chance in a hundred that the sender sits out a cycle
	int quiet      = 0;

	detector_hit_aggregator_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.det_id         (det_id),
		.energy_deposit (energy_deposit),
		.step_time      (step_time),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.done           (done),
		.status         (status),
		.hit_index      (hit_index),
		.hit_detector   (hit_detector),
		.energy_total   (energy_total),
		.first_time     (first_time),
		.first_x        (first_x),
		.first_y        (first_y),
		.first_z        (first_z)
	);

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Map a detector id to its channel; -1 when the id falls in no bank.
	function automatic int channel_of(input logic [ID_W-1:0] id);
		int n;
		int ch;
		n  = int'(id);
		ch = -1;
		if (n >= ID_GA_LO && n <= ID_GA_HI) begin
			ch = n;
		end else if (n >= ID_GB_LO && n <= ID_GB_HI) begin
			ch = GAMMA_CHANNELS + n - ID_GB_BASE;
		end else if (n >= ID_SA_LO && n <= ID_SA_HI) begin
			ch = 2 * GAMMA_CHANNELS + n - ID_SA_LO;
		end else if (n >= ID_SB_LO && n <= ID_SB_HI) begin
			ch = 2 * GAMMA_CHANNELS + SILICON_PER_BANK + n - ID_SB_LO;
		end
		return ch;
	endfunction

	// Apply one accepted request to the model state and return the result it owes.
	function automatic hit_report_t aggregate_step(input step_req_t q);
		hit_report_t r;
		int ch;
		logic [HIT_W-1:0] h;
		logic [ENERGY_W:0] sum;
		r  = '0;
		ch = channel_of(q.id);
		if (q.cmd == CMD_EOE) begin
			// End of event: drop every open channel, restart hit numbering.
			chan_open   = '0;
			hits_opened = '0;
			r.st        = STAT_CLEAR;
		end else if (q.dep == '0) begin
			// A zero deposit is dropped before the id is even looked at.
			r.st = STAT_ZERO;
		end else if (ch < 0) begin
			r.st  = STAT_UNKNOWN;
			r.det = q.id;
		end else if (!chan_open[ch] && hits_opened >= COUNT_W'(HIT_STORE_DEPTH)) begin
			// Hit store full: reported like an unknown id, state kept.
			r.st  = STAT_UNKNOWN;
			r.det = q.id;
		end else if (!chan_open[ch]) begin
			// First deposit on the channel in this event opens a new hit.
			h              = hits_opened[HIT_W-1:0];
			chan_open[ch]  = 1'b1;
			chan_hit[ch]   = h;
			hit_energy[h]  = ENERGY_W'(q.dep);
			hits_opened    = hits_opened + COUNT_W'(1);
			r.st           = STAT_NEW;
			r.hit_idx      = h;
			r.det          = q.id;
			r.energy       = ENERGY_W'(q.dep);
			r.t_first      = q.t;
			r.x0           = q.x;
			r.y0           = q.y;
			r.z0           = q.z;
		end else begin
			// Later deposit: add to the open hit, saturate at all ones.
			h   = chan_hit[ch];
			sum = {1'b0, hit_energy[h]} + (ENERGY_W + 1)'(q.dep);
			if (sum[ENERGY_W])
				sum = {1'b0, {ENERGY_W{1'b1}}};
			hit_energy[h] = sum[ENERGY_W-1:0];
			r.st          = STAT_ADD;
			r.hit_idx     = h;
			r.det         = q.id;
			r.energy      = sum[ENERGY_W-1:0];
		end
		return r;
	endfunction

	function automatic step_req_t make_step(input logic cmd, input logic [ID_W-1:0] id,
			input logic [DEP_W-1:0] dep, input logic [TIME_W-1:0] t,
			input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
			input logic [POS_W-1:0] z);
		step_req_t q;
		q.cmd = cmd;
		q.id  = id;
		q.dep = dep;
		q.t   = t;
		q.x   = x;
		q.y   = y;
		q.z   = z;
		return q;
	endfunction

	function automatic hit_report_t make_report(input logic [STATUS_W-1:0] st,
			input logic [OUT_IDX_W-1:0] idx, input logic [ID_W-1:0] det,
			input logic [ENERGY_W-1:0] energy, input logic [TIME_W-1:0] t0,
			input logic [POS_W-1:0] x0, input logic [POS_W-1:0] y0,
			input logic [POS_W-1:0] z0);
		hit_report_t r;
		r.st      = st;
		r.hit_idx = idx;
		r.det     = det;
		r.energy  = energy;
		r.t_first = t0;
		r.x0      = x0;
		r.y0      = y0;
		r.z0      = z0;
		return r;
	endfunction

	// Deposit of random magnitude, so small and large sums both occur; may be zero.
	function automatic logic [DEP_W-1:0] rand_deposit();
		int k;
		k = $urandom_range(DEP_W, 1);
		return DEP_W'($urandom & ((32'd1 << k) - 1));
	endfunction

	function automatic logic [DEP_W-1:0] nonzero_deposit();
		logic [DEP_W-1:0] d;
		d = rand_deposit();
		if (d == '0)
			d = DEP_W'(1);
		return d;
	endfunction

	// Pick a channel id from one of the four banks.
	function automatic logic [ID_W-1:0] rand_channel_id();
		int n;
		case ($urandom_range(3))
			0: n = $urandom_range(ID_GA_HI, ID_GA_LO);
			1: n = $urandom_range(ID_GB_HI, ID_GB_LO);
			2: n = $urandom_range(ID_SA_HI, ID_SA_LO);
			default: n = $urandom_range(ID_SB_HI, ID_SB_LO);
		endcase
		return ID_W'(n);
	endfunction

	function automatic logic [ID_W-1:0] rand_unknown_id();
		logic [ID_W-1:0] id;
		do
			id = ID_W'($urandom);
		while (channel_of(id) >= 0);
		return id;
	endfunction

	// Deposit step with random time and position.
	function automatic step_req_t step_at(input logic [ID_W-1:0] id,
			input logic [DEP_W-1:0] dep);
		return make_step(CMD_STEP, id, dep, $urandom, POS_W'($urandom),
			POS_W'($urandom), POS_W'($urandom));
	endfunction

	// End of event with garbage on the fields the block must ignore.
	function automatic step_req_t junk_eoe();
		step_req_t q;
		q     = step_at(ID_W'($urandom), DEP_W'($urandom));
		q.cmd = CMD_EOE;
		return q;
	endfunction

	task automatic row(input step_req_t q, input bit typed, input hit_report_t want);
		dir_req.push_back(q);
		dir_typed.push_back(typed);
		dir_want.push_back(want);
	endtask

	// Send one request: sit out random cycles, raise start, hold until taken.
	// Record the owed result at the accepting edge; a typed expectation
	// replaces the model's output while the model state still advances.
	task automatic send_request(input step_req_t q, input bit typed,
			input hit_report_t want);
		hit_report_t model;
		while ($urandom_range(99) < idle_pct) begin
			// Drop start and put noise on the payload; the block must ignore it.
			start          <= 1'b0;
			command        <= 1'($urandom);
			det_id         <= ID_W'($urandom);
			energy_deposit <= DEP_W'($urandom);
			step_time      <= $urandom;
			pos_x          <= POS_W'($urandom);
			pos_y          <= POS_W'($urandom);
			pos_z          <= POS_W'($urandom);
			@(posedge clk);
		end
		start          <= 1'b1;
		command        <= q.cmd;
		det_id         <= q.id;
		energy_deposit <= q.dep;
		step_time      <= q.t;
		pos_x          <= q.x;
		pos_y          <= q.y;
		pos_z          <= q.z;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		model = aggregate_step(q);
		hit_reports_due.push_back(typed ? want : model);
		live_steps++;
	endtask

	// Random event: a handful of channels, steps spread over them, some zero
	// deposits and stray ids. Leave it open when close is low, so hits pile up.
	task automatic channel_event(input bit close);
		logic [ID_W-1:0] chans[$];
		int pick;
		repeat ($urandom_range(10, 1))
			chans.push_back(rand_channel_id());
		repeat ($urandom_range(30, 1)) begin
			pick = $urandom_range(99);
			if (pick < 8)
				send_request(step_at(chans[$urandom_range(chans.size() - 1)], '0), 1'b0, '0);
			else if (pick < 13)
				send_request(step_at(rand_unknown_id(), nonzero_deposit()), 1'b0, '0);
			else
				send_request(step_at(chans[$urandom_range(chans.size() - 1)],
					nonzero_deposit()), 1'b0, '0);
		end
		if (close)
			send_request(junk_eoe(), 1'b0, '0);
	endtask

	// Hold start low until every owed result has come out.
	task automatic wait_for_reports();
		start <= 1'b0;
		do
			@(posedge clk);
		while (hit_reports_due.size() != 0);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
		end
	endtask

	// Result monitor: every done pulse must match the oldest owed result.
	always @(posedge clk) begin
		hit_report_t want;
		if (done === 1'b1) begin
			if (hit_reports_due.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: result with none expected: status %h, index %h, detector %h",
						$time, status, hit_index, hit_detector);
			end else begin
				want = hit_reports_due.pop_front();
				check_field("status", 32'(want.st), 32'(status));
				check_field("hit_index", 32'(want.hit_idx), 32'(hit_index));
				check_field("hit_detector", 32'(want.det), 32'(hit_detector));
				check_field("energy_total", want.energy, energy_total);
				check_field("first_time", want.t_first, first_time);
				check_field("first_x", {12'b0, want.x0}, {12'b0, first_x});
				check_field("first_y", {12'b0, want.y0}, {12'b0, first_y});
				check_field("first_z", {12'b0, want.z0}, {12'b0, first_z});
			end
		end
	end

	// Watchdog: count cycles in which neither a request nor a result moves.
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("** detector_hit_aggregator_top: FAILED **");
			$finish;
		end
	end

	initial begin
		int i;
		int n;
		int k;
		int phase;
		int base;
		int pick;
		int tmp;
		int all_ids[$];
		logic [ID_W-1:0] sat_id;
		bit saturated;
		bit filled;
		int idle_plan[4];

		// Sender idling per phase: none, heavy, none, light.
		idle_plan[0] = 0;
		idle_plan[1] = 72;
		idle_plan[2] = 0;
		idle_plan[3] = 22;
		saturated = 1'b0;
		filled    = 1'b0;

		// Directed table. Typed rows carry the result that is plain at a glance:
		// the clears, the zero deposits, the stray ids and the first hits.
		// Clear straight out of reset, every ignored field at all ones.
		row(make_step(CMD_EOE, 9'h1FF, 24'hFFFFFF, 32'hFFFFFFFF, 20'hFFFFF, 20'hFFFFF,
			20'hFFFFF), 1'b1, make_report(STAT_CLEAR, '0, '0, '0, '0, '0, '0, '0));
		// Zero deposit wins over any id, known or not.
		row(make_step(CMD_STEP, 9'd5, 24'h000000, 32'h12345678, 20'h00001, 20'h00002,
			20'h00003), 1'b1, make_report(STAT_ZERO, '0, '0, '0, '0, '0, '0, '0));
		row(make_step(CMD_STEP, 9'd0, 24'h000000, 32'hFFFFFFFF, 20'h80000, 20'h7FFFF,
			20'hFFFFF), 1'b1, make_report(STAT_ZERO, '0, '0, '0, '0, '0, '0, '0));
		// Ids just outside each bank, plus both id extremes.
		row(make_step(CMD_STEP, 9'd0, 24'h000001, 32'h0, 20'h0, 20'h0, 20'h0), 1'b1,
			make_report(STAT_UNKNOWN, '0, 9'd0, '0, '0, '0, '0, '0));
		row(make_step(CMD_STEP, 9'd511, 24'hFFFFFF, 32'hFFFFFFFF, 20'h7FFFF, 20'h80000,
			20'h7FFFF), 1'b1, make_report(STAT_UNKNOWN, '0, 9'd511, '0, '0, '0, '0, '0));
		row(make_step(CMD_STEP, 9'd111, 24'h000010, 32'h1, 20'h1, 20'h1, 20'h1), 1'b1,
			make_report(STAT_UNKNOWN, '0, 9'd111, '0, '0, '0, '0, '0));
		row(make_step(CMD_STEP, 9'd400, 24'h000010, 32'h2, 20'h2, 20'h2, 20'h2), 1'b1,
			make_report(STAT_UNKNOWN, '0, 9'd400, '0, '0, '0, '0, '0));
		row(make_step(CMD_STEP, 9'd199, 24'h000010, 32'h3, 20'h3, 20'h3, 20'h3), 1'b1,
			make_report(STAT_UNKNOWN, '0, 9'd199, '0, '0, '0, '0, '0));
		row(make_step(CMD_STEP, 9'd224, 24'h000010, 32'h4, 20'h4, 20'h4, 20'h4), 1'b1,
			make_report(STAT_UNKNOWN, '0, 9'd224, '0, '0, '0, '0, '0));
		row(make_step(CMD_STEP, 9'd299, 24'h000010, 32'h5, 20'h5, 20'h5, 20'h5), 1'b1,
			make_report(STAT_UNKNOWN, '0, 9'd299, '0, '0, '0, '0, '0));
		row(make_step(CMD_STEP, 9'd324, 24'h000010, 32'h6, 20'h6, 20'h6, 20'h6), 1'b1,
			make_report(STAT_UNKNOWN, '0, 9'd324, '0, '0, '0, '0, '0));
		// First hits of the event with payload extremes.
		row(make_step(CMD_STEP, 9'd1, 24'hFFFFFF, 32'hFFFFFFFF, 20'h80000, 20'h7FFFF,
			20'hFFFFF), 1'b1, make_report(STAT_NEW, 9'd0, 9'd1, 32'h00FFFFFF,
			32'hFFFFFFFF, 20'h80000, 20'h7FFFF, 20'hFFFFF));
		row(make_step(CMD_STEP, 9'd110, 24'h000001, 32'h0, 20'h0, 20'h0, 20'h0), 1'b1,
			make_report(STAT_NEW, 9'd1, 9'd110, 32'h1, 32'h0, 20'h0, 20'h0, 20'h0));
		// Edges of the other three banks.
		row(make_step(CMD_STEP, 9'd401, 24'h000100, 32'h1000, 20'h00010, 20'hFFFF0,
			20'h12345), 1'b0, '0);
		row(make_step(CMD_STEP, 9'd510, 24'h800000, 32'h80000000, 20'h40000, 20'hC0000,
			20'h00000), 1'b0, '0);
		row(make_step(CMD_STEP, 9'd200, 24'h000fff, 32'h7FFFFFFF, 20'h55555, 20'hAAAAA,
			20'h0F0F0), 1'b0, '0);
		row(make_step(CMD_STEP, 9'd223, 24'h555555, 32'h5A5A5A5A, 20'hAAAAA, 20'h55555,
			20'hF0F0F), 1'b0, '0);
		row(make_step(CMD_STEP, 9'd300, 24'hAAAAAA, 32'hA5A5A5A5, 20'h00001, 20'hFFFFE,
			20'h7FFFF), 1'b0, '0);
		row(make_step(CMD_STEP, 9'd323, 24'h000002, 32'hDEADBEEF, 20'h80000, 20'h80000,
			20'h80000), 1'b0, '0);
		// Adds onto open hits, back to back on the same channel.
		row(make_step(CMD_STEP, 9'd1, 24'hFFFFFF, 32'h11111111, 20'h11111, 20'h22222,
			20'h33333), 1'b0, '0);
		row(make_step(CMD_STEP, 9'd1, 24'h000001, 32'h22222222, 20'h44444, 20'h55555,
			20'h66666), 1'b0, '0);
		row(make_step(CMD_STEP, 9'd510, 24'h7FFFFF, 32'h33333333, 20'h0, 20'h0, 20'h0),
			1'b0, '0);
		// Zero deposit on an open channel leaves the hit alone.
		row(make_step(CMD_STEP, 9'd1, 24'h000000, 32'h44444444, 20'h1, 20'h2, 20'h3),
			1'b1, make_report(STAT_ZERO, '0, '0, '0, '0, '0, '0, '0));
		row(make_step(CMD_EOE, 9'h000, 24'h000000, 32'h0, 20'h0, 20'h0, 20'h0), 1'b1,
			make_report(STAT_CLEAR, '0, '0, '0, '0, '0, '0, '0));
		// After the clear the same channel opens hit zero again.
		row(make_step(CMD_STEP, 9'd1, 24'h000010, 32'h1, 20'h1, 20'h2, 20'h3), 1'b1,
			make_report(STAT_NEW, 9'd0, 9'd1, 32'h10, 32'h1, 20'h1, 20'h2, 20'h3));

		// Hold reset, then release it on a rising edge.
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < dir_req.size(); i++)
			send_request(dir_req[i], dir_typed[i], dir_want[i]);
		wait_for_reports();
		send_request(junk_eoe(), 1'b0, '0);

		// Random part in four idling phases, each drained at its end.
		base = live_steps;
		for (phase = 0; phase < 4; phase++) begin
			idle_pct = idle_plan[phase];
			while (live_steps < base + RANDOM_STEPS * (phase + 1) / 4) begin
				if (phase == 0 && !saturated) begin
					// Pound one channel with near-full deposits until the sum pins.
					saturated = 1'b1;
					sat_id    = rand_channel_id();
					repeat (280)
						send_request(step_at(sat_id, 24'hFFFFFF - DEP_W'($urandom_range(255))),
							1'b0, '0);
					send_request(junk_eoe(), 1'b0, '0);
				end else if (phase == 2 && !filled) begin
					// Open every channel in shuffled order so hit indexes climb high.
					filled = 1'b1;
					all_ids.delete();
					for (n = ID_GA_LO; n <= ID_GA_HI; n++) all_ids.push_back(n);
					for (n = ID_GB_LO; n <= ID_GB_HI; n++) all_ids.push_back(n);
					for (n = ID_SA_LO; n <= ID_SA_HI; n++) all_ids.push_back(n);
					for (n = ID_SB_LO; n <= ID_SB_HI; n++) all_ids.push_back(n);
					for (n = all_ids.size() - 1; n > 0; n--) begin
						k          = $urandom_range(n);
						tmp        = all_ids[n];
						all_ids[n] = all_ids[k];
						all_ids[k] = tmp;
					end
					for (n = 0; n < all_ids.size(); n++)
						send_request(step_at(ID_W'(all_ids[n]), nonzero_deposit()), 1'b0, '0);
					repeat (40)
						send_request(step_at(rand_channel_id(), nonzero_deposit()), 1'b0, '0);
					send_request(junk_eoe(), 1'b0, '0);
				end else begin
					pick = $urandom_range(99);
					if (pick < 70) begin
						channel_event(1'b1);
					end else if (pick < 85) begin
						channel_event(1'b0);
					end else begin
						// Noise: anything the ports allow, clears now and then.
						repeat ($urandom_range(12, 1)) begin
							if ($urandom_range(7) == 0)
								send_request(junk_eoe(), 1'b0, '0);
							else
								send_request(step_at(ID_W'($urandom), rand_deposit()), 1'b0, '0);
						end
					end
				end
				// Now and then let the block run dry before the next event.
				if ($urandom_range(3) == 0)
					wait_for_reports();
			end
			wait_for_reports();
		end

		// Drain, then let any stray results show up before the verdict.
		wait_for_reports();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("** detector_hit_aggregator_top: PASSED **");
		else
			$display("** detector_hit_aggregator_top: FAILED **");
		$finish;
	end

endmodule
